// ----- rtl/core/sha1h_pkg.sv -----
// Shared constants and types for the SHA-1 message hasher.
// Holds the initial hash values, round constants, queue sizing and the
// command and control types passed between the front, queue, back and core.
package sha1h_pkg;

	localparam int MAX_MESSAGE_BYTES = 512;
	localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int ROUNDS = 80;
	localparam int RND_W = $clog2(ROUNDS + 1);

	localparam int DIGEST_W = 160;

	typedef logic [15:0][31:0] block_t;
	typedef logic [4:0][31:0] chain_t;

	localparam chain_t SHA1_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_ROUND0 = 32'h5A827999;
	localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
	} core_stat_t;

endpackage

// ----- rtl/core/sha1h_front.sv -----
// Input side of the SHA-1 hasher: accepts stream transfers and turns them
// into commands. Depends on sha1h_pkg for the command type.
module sha1h_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic [0:0]         s_tuser,   // [0] has_byte
	input  logic               s_tlast,
	output logic               push,
	output sha1h_pkg::cmd_t    push_cmd,
	input  logic               full
);
	import sha1h_pkg::*;

	logic take;

	// Items that carry no byte and do not end the message have no effect.
	assign s_tready = !full;
	assign take = s_tvalid && s_tready;
	assign push = take && (s_tuser[0] || s_tlast);

	always_comb begin
		push_cmd.data_byte = s_tdata;
		push_cmd.has_byte = s_tuser[0];
		push_cmd.last = s_tlast;
	end

endmodule

// ----- rtl/core/sha1h_queue.sv -----
// Short command queue between the front and back of the SHA-1 hasher.
// Depends on sha1h_pkg for the command type and queue depth.
module sha1h_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sha1h_pkg::cmd_t    push_cmd,
	output logic               full,
	input  logic               pop,
	output sha1h_pkg::cmd_t    pop_cmd,
	output logic               empty
);
	import sha1h_pkg::*;

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                do_push;
	logic                do_pop;

	assign full = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/sha1h_core.sv -----
// SHA-1 compression core: one round per cycle over a 16-word schedule
// shift register, then a fold of the working words into the chaining words.
// Depends on sha1h_pkg for constants and types.
module sha1h_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1h_pkg::core_ctl_t  ctl,
	output sha1h_pkg::core_stat_t stat,
	input  sha1h_pkg::block_t     blk,
	output sha1h_pkg::chain_t     chain
);
	import sha1h_pkg::*;

	chain_t             chain_q;
	logic               busy_q;
	logic [RND_W-1:0]   rnd_q;
	logic [31:0]        a_q, b_q, c_q, d_q, e_q;
	block_t             w_q;
	logic [31:0]        f;
	logic [31:0]        k;
	logic [31:0]        tmp;
	logic [31:0]        mix;
	logic               folding;

	assign stat.busy = busy_q;
	assign chain = chain_q;
	assign folding = (rnd_q == RND_W'(ROUNDS));

	always_comb begin
		if (rnd_q < RND_W'(20)) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_ROUND0;
		end else if (rnd_q < RND_W'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = K_ROUND1;
		end else if (rnd_q < RND_W'(60)) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_ROUND2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_ROUND3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
			chain_q <= SHA1_IV;
		end else begin
			if (ctl.init) begin
				chain_q <= SHA1_IV;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (folding) begin
					busy_q <= 1'b0;
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
			w_q <= blk;
		end else if (busy_q && !folding) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			w_q <= {{mix[30:0], mix[31]}, w_q[15:1]};
		end
	end

endmodule

// ----- rtl/core/sha1h_back.sv -----
// Back end of the SHA-1 hasher: byte counting, block buffer, padding,
// sequencing of the compression core and the result register.
// Depends on sha1h_pkg and instantiates sha1h_core.
module sha1h_back (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      pop,
	input  sha1h_pkg::cmd_t           pop_cmd,
	input  logic                      empty,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sha1h_pkg::DIGEST_W-1:0] out_digest,
	output logic                      out_too_long
);
	import sha1h_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RUN  = 6'b000010,
		ST_WAIT = 6'b000100,
		ST_PAD  = 6'b001000,
		ST_LEN  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_MESSAGE_BYTES);

	state_t              state_q;
	state_t              after_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_inc;
	block_t              blk_q;
	logic                out_valid_q;
	logic [DIGEST_W-1:0] out_digest_q;
	logic                out_too_long_q;

	core_ctl_t           core_ctl;
	core_stat_t          core_stat;
	chain_t              chain;

	logic [5:0]          pos;
	logic [3:0]          idx;
	logic                fits;
	logic                over;
	logic                out_free;
	logic [63:0]         len_bits;
	logic                wr_en;
	logic [7:0]          wr_byte;
	logic                zero_above;
	logic                len_en;
	logic                clear_all;

	assign pos = count_q[5:0];
	assign idx = pos[5:2];
	assign fits = (count_q < MAX_C);
	assign over = (count_q > MAX_C);
	assign count_inc = count_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign len_bits = {{(64 - CNT_W - 3){1'b0}}, count_q, 3'b000};

	assign pop = (state_q == ST_IDLE) && !empty;

	assign out_valid = out_valid_q;
	assign out_digest = out_digest_q;
	assign out_too_long = out_too_long_q;

	always_comb begin
		wr_en = (pop && pop_cmd.has_byte && fits) || ((state_q == ST_PAD) && !over);
		wr_byte = (state_q == ST_PAD) ? PAD_BYTE : pop_cmd.data_byte;
		zero_above = (state_q == ST_PAD) && !over;
		len_en = (zero_above && (pos < 6'd56)) || (state_q == ST_LEN);
		clear_all = (state_q == ST_LEN);
		core_ctl.start = (state_q == ST_RUN);
		core_ctl.init = out_free &&
			((state_q == ST_FIN) || ((state_q == ST_PAD) && over));
	end

	sha1h_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.stat   (core_stat),
		.blk    (blk_q),
		.chain  (chain)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			if (clear_all || (zero_above && (4'(i) > idx))) begin
				blk_q[i] <= '0;
			end
			if (wr_en && (4'(i) == idx)) begin
				case (pos[1:0])
					2'd0: blk_q[i] <= {wr_byte, 24'h000000};
					2'd1: blk_q[i][23:16] <= wr_byte;
					2'd2: blk_q[i][15:8] <= wr_byte;
					default: blk_q[i][7:0] <= wr_byte;
				endcase
			end
		end
		if (len_en) begin
			blk_q[14] <= len_bits[63:32];
			blk_q[15] <= len_bits[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			out_digest_q <= '0;
			out_too_long_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (pop_cmd.has_byte && fits) begin
							count_q <= count_inc;
							if (count_inc[5:0] == 6'd0) begin
								state_q <= ST_RUN;
								after_q <= pop_cmd.last ? ST_PAD : ST_IDLE;
							end else if (pop_cmd.last) begin
								state_q <= ST_PAD;
							end
						end else begin
							if (pop_cmd.has_byte) begin
								count_q <= MAX_C + 1'b1;
							end
							if (pop_cmd.last) begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_RUN: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!core_stat.busy) begin
						state_q <= after_q;
					end
				end
				ST_PAD: begin
					if (over) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_digest_q <= '0;
							out_too_long_q <= 1'b1;
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_RUN;
						after_q <= (pos >= 6'd56) ? ST_LEN : ST_FIN;
					end
				end
				ST_LEN: begin
					state_q <= ST_RUN;
					after_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_digest_q <= {chain[4], chain[2], chain[3], chain[0], chain[1]};
						out_too_long_q <= 1'b0;
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/sha1_message_hasher.sv -----
// Top level of the SHA-1 message hasher: front end, command queue and
// back end with its compression core. Depends on sha1h_pkg.
//
//  Group   Dir  Payload                                        Marks
//  s_*     in   tdata[7:0] data_byte                           tuser[0] has_byte, tlast last
//  m_*     out  tdata[63:0] upper, [127:64] middle, [159:128] lower  tuser[0] too_long
//
// The back end takes one queued item at a time while idle; each full 64-byte
// block holds it through load, rounds, fold and hand-back. A last item adds
// a padding and a result step, a length step when the length needs its own
// block, and one or two blocks; a refused message adds only a padding step.
// Reset clears all control state; the chaining words return to their
// initial values. The four-entry queue keeps taking items until full while the core
// runs, and a finished digest waits in its register without stopping input.
module sha1_message_hasher (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic [0:0]    s_tuser,   // [0] has_byte
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [159:0]  m_tdata,   // [63:0] digest_upper, [127:64] digest_middle,
	                                 // [159:128] digest_lower
	output logic [0:0]    m_tuser    // [0] too_long
);
	import sha1h_pkg::*;

	logic  push;
	cmd_t  push_cmd;
	logic  full;
	logic  pop;
	cmd_t  pop_cmd;
	logic  empty;
	logic  too_long;

	sha1h_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	sha1h_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	sha1h_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_cmd      (pop_cmd),
		.empty        (empty),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_digest   (m_tdata),
		.out_too_long (too_long)
	);

	assign m_tuser[0] = too_long;

endmodule
